// ===== hdl/butterworth_lowpass_biquad_defines.svh =====
// Assertion macros shared by the biquad checker.
`ifndef BUTTERWORTH_LOWPASS_BIQUAD_DEFINES_SVH
`define BUTTERWORTH_LOWPASS_BIQUAD_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define BQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication that also holds through reset
`define BQ_ASSERT_ALW(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/bwbq_pkg.sv =====
// Package: shared constants, codes and controller/datapath types of the biquad.
package bwbq_pkg;

   localparam int DEF_SAMPLE_WIDTH = 16;
   localparam int DEF_COEF_WIDTH   = 20;

   // internal fixed-point formats
   localparam int CORE_SAMPLE_W = 16;   // Q1.15
   localparam int CORE_COEF_W   = 20;   // Q4.16
   localparam int DELAY_W       = 36;   // Q6.30
   localparam int PROD_W        = CORE_COEF_W + CORE_SAMPLE_W;   // gain * x, Q.31
   localparam int Y_W           = DELAY_W + 2;                  // y, Q.31
   localparam int MUL_W         = CORE_COEF_W + Y_W;
   localparam int ACC_W         = MUL_W + 2;                    // Q.47 accumulators
   localparam int ACC_SHIFT     = 17;                           // 47 -> 30 fraction bits
   localparam int NEXT_W        = ACC_W - ACC_SHIFT;
   localparam int ACC_ROUND     = 1 << (ACC_SHIFT - 1);
   localparam int COEF_ONE      = 65536;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN = 2'd0,
      CSR_FB1  = 2'd1,
      CSR_FB2  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_GAIN,
      MUL_FB1,
      MUL_FB2
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_FB1,
      ST_FB2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sum_en;
      logic        acc1_en;
      logic        finish;
   } dp_cmd_type;

endpackage

// ===== hdl/butterworth_lowpass_biquad.sv =====
// Top level: second-order lowpass biquad, transposed direct form II.
//
// Samples enter on the req_ channel (req_valid / req_stall) and results leave on
// the rsp_ channel (rsp_valid / rsp_stall); a beat moves when valid is high and
// stall is low. Coefficients are written through csr_write / csr_index / csr_wdata
// (0 gain, 1 first feedback, 2 second feedback); the user must write them only
// while no sample is in flight, as the block itself does not enforce it. Each
// sample uses the single shared 20 x 38 bit multiplier three times (gain, a1,
// a2): the gain product is taken as the sample is accepted, y is then formed from
// the gain product and the first delay, the a1 and a2 products follow, and a last
// step rounds, checks and writes the result; only then is a new sample accepted.
// The result sits in an output register, so the next sample is taken while it
// waits. If rsp_stall holds, the following sample is computed up to its last
// step and then waits until the output register is free; delays update only
// when its result is written.
// Reset clears coefficients and both delays; with zero coefficients the output
// is 0 and fault_reset is low. fault_reset reports a delay overflow or unstable
// coefficients, in which case the output is 0 and both delays are cleared.
module butterworth_lowpass_biquad
   import bwbq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic signed [COEF_WIDTH-1:0]   csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_fault_reset
);

   dp_cmd_type cmd;

   bwbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bwbq_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_sample_in   (req_sample_in),
      .cmd             (cmd),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_fault_reset (rsp_fault_reset)
   );

endmodule

// ===== hdl/bwbq_ctrl.sv =====
// Sequencer: steps one sample through the shared multiplier and owns the result valid.
module bwbq_ctrl
   import bwbq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_GAIN;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_FB1;
         end
         ST_FB1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FB1;
            state_in    = ST_FB2;
         end
         ST_FB2: begin
            cmd.acc1_en = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_FB2;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // delays and output register update together, once the output slot is free
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);
   end

endmodule

// ===== hdl/bwbq_datapath.sv =====
// Datapath: coefficient registers, shared multiplier, delay state and output register.
module bwbq_datapath
   import bwbq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic signed [COEF_WIDTH-1:0]   csr_wdata,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  dp_cmd_type                     cmd,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_fault_reset
);

   localparam int OUT_W     = Y_W + 2;
   localparam int OUT_SHIFT = 32 - SAMPLE_WIDTH;   // y has 31 fraction bits
   localparam logic signed [OUT_W-1:0] OUT_ROUND = (OUT_W'(1) << OUT_SHIFT) >> 1;
   localparam logic signed [OUT_W-1:0] OUT_HI = (OUT_W'(1) << (SAMPLE_WIDTH - 1)) - OUT_W'(1);
   localparam logic signed [OUT_W-1:0] OUT_LO = ~OUT_HI;
   localparam logic signed [CORE_COEF_W+1:0] COEF_ONE_W = (CORE_COEF_W + 2)'(COEF_ONE);
   localparam logic signed [ACC_W-1:0] ACC_ROUND_W = ACC_W'(ACC_ROUND);

   logic signed [CORE_SAMPLE_W-1:0] x_norm;
   logic signed [CORE_COEF_W-1:0]   coef_norm;

   logic signed [CORE_COEF_W-1:0] gain_ff, fb1_ff, fb2_ff;
   logic signed [DELAY_W-1:0]     d1_ff, d1_in, d2_ff, d2_in;
   logic signed [MUL_W-1:0]       mul_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [Y_W-1:0]         y_ff, y_in;
   logic signed [NEXT_W-1:0]      next1_ff, next1_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_out_ff, sample_out_in;
   logic                          fault_ff, fault_in;

   logic signed [CORE_COEF_W-1:0] mul_a;
   logic signed [Y_W-1:0]         mul_b;
   logic signed [Y_W-1:0]         prod_y, d1_y;
   logic signed [ACC_W-1:0]       prod_x, d2_x, mul_x, acc1, acc2;
   logic signed [NEXT_W-1:0]      next2;
   logic signed [CORE_COEF_W+1:0] fb1_w, fb2_w, fb1_abs, fb2_lim;
   logic signed [OUT_W-1:0]       y_w, y_rnd, y_shr, y_sat;
   logic                          unstable, ovf1, ovf2, fault;

   // bring sample and coefficient onto the internal formats (floor on narrowing)
   generate
      if (SAMPLE_WIDTH >= CORE_SAMPLE_W) begin : g_x_narrow
         assign x_norm = CORE_SAMPLE_W'(req_sample_in >>> (SAMPLE_WIDTH - CORE_SAMPLE_W));
      end else begin : g_x_widen
         assign x_norm = {req_sample_in, {(CORE_SAMPLE_W - SAMPLE_WIDTH){1'b0}}};
      end
      if (COEF_WIDTH >= CORE_COEF_W) begin : g_c_narrow
         assign coef_norm = CORE_COEF_W'(csr_wdata >>> (COEF_WIDTH - CORE_COEF_W));
      end else begin : g_c_widen
         assign coef_norm = {csr_wdata, {(CORE_COEF_W - COEF_WIDTH){1'b0}}};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         fb1_ff  <= '0;
         fb2_ff  <= '0;
         d1_ff   <= '0;
         d2_ff   <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_GAIN: gain_ff <= coef_norm;
               CSR_FB1:  fb1_ff  <= coef_norm;
               CSR_FB2:  fb2_ff  <= coef_norm;
               default:  ;
            endcase
         end
         if (cmd.finish) begin
            d1_ff <= d1_in;
            d2_ff <= d2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         mul_ff <= MUL_W'(mul_a) * MUL_W'(mul_b);
      end
      if (cmd.sum_en) begin
         prod_ff <= $signed(mul_ff[PROD_W-1:0]);
         y_ff    <= y_in;
      end
      if (cmd.acc1_en) begin
         next1_ff <= next1_in;
      end
      if (cmd.finish) begin
         sample_out_ff <= sample_out_in;
         fault_ff      <= fault_in;
      end
   end

   always_comb begin
      mul_a = gain_ff;
      mul_b = Y_W'(x_norm);
      unique case (cmd.mul_sel)
         MUL_GAIN: begin
            mul_a = gain_ff;
            mul_b = Y_W'(x_norm);
         end
         MUL_FB1: begin
            mul_a = fb1_ff;
            mul_b = y_ff;
         end
         MUL_FB2: begin
            mul_a = fb2_ff;
            mul_b = y_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      // y = g*x + d1, both at 31 fraction bits
      prod_y = Y_W'($signed(mul_ff[PROD_W-1:0]));
      d1_y   = Y_W'(d1_ff);
      y_in   = prod_y + (d1_y <<< 1);

      prod_x = ACC_W'(prod_ff);
      d2_x   = ACC_W'(d2_ff);
      mul_x  = ACC_W'(mul_ff);
      // d1' = 2g*x - a1*y + d2 ; d2' = g*x - a2*y ; rounded half up to 30 fraction bits
      acc1     = (prod_x <<< ACC_SHIFT) + (d2_x <<< ACC_SHIFT) - mul_x + ACC_ROUND_W;
      acc2     = (prod_x <<< (ACC_SHIFT - 1)) - mul_x + ACC_ROUND_W;
      next1_in = NEXT_W'(acc1 >>> ACC_SHIFT);
      next2    = NEXT_W'(acc2 >>> ACC_SHIFT);

      ovf1 = !((&next1_ff[NEXT_W-1:DELAY_W-1]) || !(|next1_ff[NEXT_W-1:DELAY_W-1]));
      ovf2 = !((&next2[NEXT_W-1:DELAY_W-1]) || !(|next2[NEXT_W-1:DELAY_W-1]));

      // stability triangle: |a2| < 1 and |a1| < 1 + a2
      fb1_w    = (CORE_COEF_W + 2)'(fb1_ff);
      fb2_w    = (CORE_COEF_W + 2)'(fb2_ff);
      fb1_abs  = fb1_w[CORE_COEF_W+1] ? -fb1_w : fb1_w;
      fb2_lim  = fb2_w + COEF_ONE_W;
      unstable = (fb2_w >= COEF_ONE_W) || (fb2_w <= -COEF_ONE_W) || (fb1_abs >= fb2_lim);

      fault = unstable || ovf1 || ovf2;

      y_w   = OUT_W'(y_ff);
      y_rnd = y_w + OUT_ROUND;
      y_shr = y_rnd >>> OUT_SHIFT;
      if (y_shr > OUT_HI) begin
         y_sat = OUT_HI;
      end else if (y_shr < OUT_LO) begin
         y_sat = OUT_LO;
      end else begin
         y_sat = y_shr;
      end

      d1_in         = fault ? '0 : next1_ff[DELAY_W-1:0];
      d2_in         = fault ? '0 : next2[DELAY_W-1:0];
      sample_out_in = fault ? '0 : y_sat[SAMPLE_WIDTH-1:0];
      fault_in      = fault;
   end

   assign rsp_sample_out  = sample_out_ff;
   assign rsp_fault_reset = fault_ff;

endmodule

// ===== hdl/bwbq_checker.sv =====
// Checker on the biquad's ports, bound to the top level.
`include "butterworth_lowpass_biquad_defines.svh"

module bwbq_checker
   import bwbq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                    rsp_fault_reset
);

   `BQ_ASSERT_IMP(fault_zero_a, clock, reset, rsp_valid && rsp_fault_reset, rsp_sample_out == '0, "fault beat carries a non-zero sample")
   `BQ_ASSERT_NXT(busy_after_accept_a, clock, reset, req_valid && !req_stall, req_stall, "second sample taken while one is in flight")
   `BQ_ASSERT_NXT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_fault_reset), "stalled result beat changed")
   `BQ_ASSERT_IMP(rsp_latency_a, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 5), "result beat without a sample five cycles before")
   `BQ_ASSERT_ALW(reset_clears_a, clock, $past(reset), !rsp_valid, "result valid straight after reset")

endmodule

bind butterworth_lowpass_biquad bwbq_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bwbq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_sample_out  (rsp_sample_out),
   .rsp_fault_reset (rsp_fault_reset)
);
